FILE: sv/grid_delay_word_encoder_core_assert.svh
// Assertion macros shared by the grid delay word encoder RTL.
`ifndef GRID_DELAY_WORD_ENCODER_CORE_ASSERT_SVH
`define GRID_DELAY_WORD_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDWE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid delay word encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define GDWE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid delay word encoder check failed");

`endif

FILE: sv/gdwe_pkg.sv
// Package with the word types and constants of the grid delay word encoder.
package gdwe_pkg;

    localparam int unsigned GRID_W      = 10;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned REPS_W      = 22;
    localparam int unsigned DUR_W       = 11;
    localparam int unsigned RCOUNT_W    = 16;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    localparam logic [GRID_W-1:0] GRID_RESET = 10'd32;

    localparam logic REG_GRID_PERIOD = 1'b0;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] KIND_DURATION  = 2'd0;
    localparam logic [1:0] KIND_REPEAT    = 2'd1;
    localparam logic [1:0] KIND_VIOLATION = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [TICK_W-1:0] tick_count;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          word_kind;
        logic [RCOUNT_W-1:0] repeat_count;
        logic [DUR_W-1:0]    duration;
        logic                overflow_seen;
        logic                last_word;
    } t_out_word;

endpackage

FILE: sv/grid_delay_word_encoder_core.sv
// Top level of the grid delay word encoder: accumulator, divider sequencer and word output.

// An add word passes through the idle, cap and execute states before the input is ready;
// a flush of an empty accumulator takes the same path. A flush that yields words uses the cap
// and execute states for the cap and the checks, then a one-bit-per-cycle restoring divider
// and an adjust state for the quotient (both skipped for a timing violation), and then one
// result word per cycle while the output register is free; up to MAX_REPEAT_WORDS + 1 words
// come from one flush. The input is not ready until the last word of a flush has been placed
// in the output register. The grid period register sits at byte address 0 of the APB port.
module grid_delay_word_encoder_core
    import gdwe_pkg::*;
#(
    parameter int unsigned MAX_REPEAT_WORDS     = 62,
    parameter int unsigned MAX_REPEATS_PER_WORD = 65530
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [REPS_W-1:0] CapPeriods = REPS_W'(MAX_REPEAT_WORDS * MAX_REPEATS_PER_WORD);
    localparam logic [REPS_W-1:0] MaxRep     = REPS_W'(MAX_REPEATS_PER_WORD);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CAP  = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_ADJ  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [GRID_W-1:0]   r_grid;
    logic [TICK_W-1:0]   r_pending, n_pending;
    logic                r_ovf, n_ovf;
    logic [TICK_W-1:0]   r_cap, n_cap;
    logic                r_op, n_op;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [TICK_W-1:0]   r_quot, n_quot;
    logic [GRID_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [REPS_W-1:0]   r_reps, n_reps;
    logic [DUR_W-1:0]    r_extra, n_extra;
    logic                r_single, n_single;
    logic                r_viol, n_viol;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    logic [GRID_W-1:0]   w_geff;
    logic [TICK_W-1:0]   w_cap_prod;
    logic [TICK_W:0]     w_sum;
    logic [TICK_W-1:0]   w_dur;
    logic [GRID_W:0]     w_trial;
    logic                w_qbit;
    logic [REPS_W-1:0]   w_qadj;
    logic [REPS_W-1:0]   w_chunk;
    logic [REPS_W-1:0]   w_left;
    logic                w_slot_free;
    logic                w_cfg_write;

    assign w_geff      = (r_grid == '0) ? GRID_W'(1) : r_grid;
    assign w_cap_prod  = TICK_W'({{(TICK_W-REPS_W){1'b0}}, CapPeriods}
                                 * {{(TICK_W-GRID_W){1'b0}}, w_geff});
    assign w_sum       = {1'b0, r_pending} + {1'b0, r_tick};
    assign w_dur       = (r_pending > r_cap) ? r_cap : r_pending;
    assign w_trial     = {r_rem, r_quot[TICK_W-1]};
    assign w_qbit      = (w_trial >= {1'b0, w_geff});
    assign w_qadj      = (r_rem != '0) ? (r_quot[REPS_W-1:0] - REPS_W'(1)) : r_quot[REPS_W-1:0];
    assign w_chunk     = (r_reps > MaxRep) ? MaxRep : r_reps;
    assign w_left      = r_reps - w_chunk;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_GRID_PERIOD);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[PADDR_W-1] == REG_GRID_PERIOD) ? PDATA_W'(r_grid) : '0;

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_ovf       = r_ovf;
        n_cap       = r_cap;
        n_op        = r_op;
        n_tick      = r_tick;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_reps      = r_reps;
        n_extra     = r_extra;
        n_single    = r_single;
        n_viol      = r_viol;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in_word.opcode;
                    n_tick  = i_in_word.tick_count;
                    n_state = ST_CAP;
                end
            end
            ST_CAP: begin
                n_cap   = w_cap_prod;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_op == OP_ADD) begin
                    if (w_sum > {1'b0, r_cap}) begin
                        n_pending = r_cap;
                        n_ovf     = 1'b1;
                    end else begin
                        n_pending = w_sum[TICK_W-1:0];
                    end
                    n_state = ST_IDLE;
                end else if (r_pending == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    if (r_pending > r_cap) begin
                        n_ovf = 1'b1;
                    end
                    n_pending = '0;
                    n_quot    = w_dur;
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_single  = 1'b0;
                    n_reps    = '0;
                    n_extra   = '0;
                    if (w_dur < TICK_W'(w_geff)) begin
                        n_viol  = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_viol  = 1'b0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_rem  = w_qbit ? GRID_W'(w_trial - {1'b0, w_geff}) : w_trial[GRID_W-1:0];
                n_quot = {r_quot[TICK_W-2:0], w_qbit};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_ADJ;
                end
            end
            ST_ADJ: begin
                n_extra = (r_rem != '0) ? ({1'b0, r_rem} + {1'b0, w_geff}) : '0;
                if (w_qadj == REPS_W'(1)) begin
                    n_single = 1'b1;
                    n_reps   = '0;
                end else begin
                    n_single = 1'b0;
                    n_reps   = w_qadj;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.overflow_seen = r_ovf;
                    n_out.repeat_count  = '0;
                    priority if (r_viol) begin
                        n_out.word_kind = KIND_VIOLATION;
                        n_out.duration  = r_quot[DUR_W-1:0];
                        n_out.last_word = 1'b1;
                        n_viol          = 1'b0;
                        n_state         = ST_IDLE;
                    end else if (r_single) begin
                        n_out.word_kind = KIND_DURATION;
                        n_out.duration  = {1'b0, w_geff};
                        n_out.last_word = (r_extra == '0);
                        n_single        = 1'b0;
                        if (r_extra == '0) begin
                            n_state = ST_IDLE;
                        end
                    end else if (r_reps != '0) begin
                        n_out.word_kind    = KIND_REPEAT;
                        n_out.repeat_count = w_chunk[RCOUNT_W-1:0];
                        n_out.duration     = {1'b0, w_geff};
                        n_out.last_word    = (w_left == '0) && (r_extra == '0);
                        n_reps             = w_left;
                        if ((w_left == '0) && (r_extra == '0)) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_out.word_kind = KIND_DURATION;
                        n_out.duration  = r_extra;
                        n_out.last_word = 1'b1;
                        n_extra         = '0;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grid      <= GRID_RESET;
            r_pending   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_single    <= 1'b0;
            r_viol      <= 1'b0;
            r_reps      <= '0;
            r_extra     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_single    <= n_single;
            r_viol      <= n_viol;
            r_reps      <= n_reps;
            r_extra     <= n_extra;
            r_cnt       <= n_cnt;
            if (w_cfg_write) begin
                r_grid <= pwdata[GRID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap  <= n_cap;
        r_op   <= n_op;
        r_tick <= n_tick;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_out  <= n_out;
    end

`include "grid_delay_word_encoder_core_assert.svh"

    `GDWE_ASSERT_SAME(a_div_rem_below_grid, i_clk, i_rst_n,
        (r_state == ST_DIV), (r_rem < w_geff))
    `GDWE_ASSERT_SAME(a_repeat_count_in_range, i_clk, i_rst_n,
        (r_out_valid && (r_out.word_kind == KIND_REPEAT)),
        ((r_out.repeat_count != '0) && ({6'b0, r_out.repeat_count} <= MaxRep)))
    `GDWE_ASSERT_SAME(a_violation_is_last, i_clk, i_rst_n,
        (r_out_valid && (r_out.word_kind == KIND_VIOLATION)), r_out.last_word)
    `GDWE_ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, r_ovf, r_ovf)

endmodule
